### design/gsp_pkg.sv
// Shared types, constants and helpers for the geo-to-screen projection core.
`default_nettype none
package gsp_pkg;
  localparam int REM_W = 52;
  localparam int Q_W = 18;
  localparam int SPAN_W = 34;
  localparam logic signed [34:0] FULL_TURN = 35'sd3600000000;

  localparam logic [3:0] REG_MIN_LON = 4'd0;
  localparam logic [3:0] REG_MAX_LON = 4'd1;
  localparam logic [3:0] REG_MIN_LAT = 4'd2;
  localparam logic [3:0] REG_MAX_LAT = 4'd3;
  localparam logic [3:0] REG_WIDTH = 4'd4;
  localparam logic [3:0] REG_HEIGHT = 4'd5;
  localparam logic [3:0] REG_OFF_X = 4'd6;
  localparam logic [3:0] REG_OFF_Y = 4'd7;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0] q;
    logic neg;
    logic ovf;
    logic zero;
  } lane_t;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v < -22'sd32768) begin
      return -16'sd32768;
    end else if (v > 22'sd32767) begin
      return 16'sd32767;
    end
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

### design/gsp_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both lanes.
`default_nettype none
module gsp_div_cell #(
  parameter int BIT = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_in,
  input  wire gsp_pkg::lane_t x_in,
  input  wire gsp_pkg::lane_t y_in,
  input  wire logic [gsp_pkg::SPAN_W-1:0] span_x,
  input  wire logic [gsp_pkg::SPAN_W-1:0] span_y,
  output logic valid_out,
  output gsp_pkg::lane_t x_out,
  output gsp_pkg::lane_t y_out
);
  import gsp_pkg::*;

  function automatic lane_t step(input lane_t l, input logic [SPAN_W-1:0] s);
    logic [REM_W:0] d;
    lane_t r;
    d = {1'b0, l.rem} - ({{(REM_W + 1 - SPAN_W){1'b0}}, s} << BIT);
    r = l;
    if (!d[REM_W]) begin
      r.rem = d[REM_W-1:0];
      r.q[BIT] = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    x_out <= step(x_in, span_x);
    y_out <= step(y_in, span_y);
  end
endmodule
`default_nettype wire

### design/geo_to_screen_projection_core.sv
// Top level of the equirectangular geo-to-screen projection core.
// Takes one point per cycle (busy stays low) and gives its screen coordinates
// on a one-cycle done strobe, after the operand, multiply and magnitude
// stages, a row of 18 division cells, one quotient bit each, and the output
// register. The receiver cannot stall.
// Config writes are always ready.
`default_nettype none
module geo_to_screen_projection_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [31:0] longitude,
  input  wire logic signed [30:0] latitude,
  output logic done,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [3:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import gsp_pkg::*;

  localparam int LAT = Q_W + 4;

  logic signed [31:0] min_lon, max_lon;
  logic signed [30:0] min_lat, max_lat;
  logic [14:0] width, height;
  logic signed [15:0] off_x, off_y;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_lon <= -32'sd1800000000;
      max_lon <= 32'sd1800000000;
      min_lat <= -31'sd900000000;
      max_lat <= 31'sd900000000;
      width <= 15'd320;
      height <= 15'd240;
      off_x <= '0;
      off_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_LON: min_lon <= cfg_data;
        REG_MAX_LON: max_lon <= cfg_data;
        REG_MIN_LAT: min_lat <= cfg_data[30:0];
        REG_MAX_LAT: max_lat <= cfg_data[30:0];
        REG_WIDTH: width <= cfg_data[14:0];
        REG_HEIGHT: height <= cfg_data[14:0];
        REG_OFF_X: off_x <= cfg_data[15:0];
        REG_OFF_Y: off_y <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic wraps;
  logic signed [34:0] span_x_s, dx_c;
  logic signed [31:0] span_y_s;
  logic [SPAN_W-1:0] span_x_mag, span_y_mag;
  logic span_x_pos, span_y_pos;

  always_comb begin
    wraps = min_lon > max_lon;
    span_x_s = 35'(max_lon) - 35'(min_lon) + (wraps ? FULL_TURN : 35'sd0);
    span_y_s = 32'(max_lat) - 32'(min_lat);
    span_x_pos = span_x_s > 35'sd0;
    span_y_pos = span_y_s > 32'sd0;
    span_x_mag = span_x_s[SPAN_W-1:0];
    span_y_mag = {2'b00, span_y_s};
    dx_c = 35'(longitude) - 35'(min_lon);
    if (wraps && dx_c < 35'sd0) begin
      dx_c = dx_c + FULL_TURN;
    end
  end

  logic v0, v1, v2;
  logic signed [34:0] dx;
  logic signed [31:0] dy;
  logic signed [50:0] px_prod;
  logic signed [47:0] py_prod;
  lane_t x2, y2;

  function automatic lane_t prep(input logic signed [50:0] p, input logic [SPAN_W-1:0] s,
                                 input logic pos);
    lane_t l;
    logic [50:0] m;
    m = p[50] ? 51'(-p) : 51'(p);
    l.rem = REM_W'(m);
    l.q = '0;
    l.neg = p[50];
    l.ovf = {2'b00, m} >= ({19'b0, s} << Q_W);
    l.zero = !pos;
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
      v2 <= v1;
    end
    dx <= dx_c;
    dy <= 32'(latitude) - 32'(min_lat);
    px_prod <= 51'(dx) * 51'($signed({1'b0, width}));
    py_prod <= 48'(dy) * 48'($signed({1'b0, height}));
    x2 <= prep(px_prod, span_x_mag, span_x_pos);
    y2 <= prep(51'(py_prod), span_y_mag, span_y_pos);
  end

  logic v_c [0:Q_W];
  lane_t x_c [0:Q_W];
  lane_t y_c [0:Q_W];

  assign v_c[0] = v2;
  assign x_c[0] = x2;
  assign y_c[0] = y2;

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    gsp_div_cell #(.BIT(Q_W - 1 - k)) u_cell (
      .clk(clk),
      .rst(rst),
      .valid_in(v_c[k]),
      .x_in(x_c[k]),
      .y_in(y_c[k]),
      .span_x(span_x_mag),
      .span_y(span_y_mag),
      .valid_out(v_c[k+1]),
      .x_out(x_c[k+1]),
      .y_out(y_c[k+1])
    );
  end

  function automatic logic signed [19:0] quot(input lane_t l);
    logic [19:0] m;
    m = l.zero ? 20'd0 : (l.ovf ? 20'd262144 : {2'b00, l.q});
    return l.neg ? -$signed(m) : $signed(m);
  endfunction

  logic signed [19:0] qx, qy;
  logic signed [21:0] sx, sy;

  always_comb begin
    qx = quot(x_c[Q_W]);
    qy = quot(y_c[Q_W]);
    sx = 22'(qx) + 22'(off_x);
    if (y_c[Q_W].zero) begin
      sy = 22'(off_y);
    end else begin
      sy = $signed({7'b0, height}) - 22'(qy) + 22'(off_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_c[Q_W];
    end
    screen_x <= sat16(sx);
    screen_y <= sat16(sy);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##LAT done)
    else $error("request did not complete at fixed latency");
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request");
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    (v_c[Q_W] && x_c[Q_W].ovf && !x_c[Q_W].zero && !x_c[Q_W].neg) |=>
    (screen_x == 16'sd32767))
    else $error("x overflow not saturated");
endmodule
`default_nettype wire
